@@ rtl/bbm_pkg.sv @@
// ----------------------------------------------------------------------------
// bbm_pkg
// Shared types, constants and divide tables for the 3x3 edge-aware box blur.
// ----------------------------------------------------------------------------
`default_nettype none

package bbm_pkg;

    // field and register widths
    localparam int SAMPLE_W   = 16;
    localparam int CFG_DATA_W = 13;
    localparam int ROW_W      = 12;

    // register reset values and limits
    localparam int FRAME_WIDTH_RESET  = 32;
    localparam int FRAME_HEIGHT_RESET = 32;
    localparam int MAX_HEIGHT         = 4096;

    // register indexes on the configuration port
    localparam logic REG_FRAME_WIDTH  = 1'b0;
    localparam logic REG_FRAME_HEIGHT = 1'b1;

    // result buffer depth (power of two)
    localparam int FIFO_DEPTH = 8;

    // mean datapath: the biased sum is always non-negative and below 2^20
    localparam int COL_SUM_W   = 18;
    localparam int SUM_W       = 20;
    localparam int RECIP_W     = 25;
    localparam int RECIP_SHIFT = 24;
    localparam int OFFSET_W    = 19;
    localparam int PROD_W      = SUM_W + RECIP_W;
    // 36 * 8192: a multiple of every divisor, equal in magnitude to nine full-scale negatives
    localparam logic [SUM_W-1:0] SUM_BIAS = 20'd294912;

    typedef logic signed [SAMPLE_W-1:0] sample_t;

    // 3x3 window, indexed [row][col]; row 2 is the newest row, col 2 the newest column
    typedef sample_t [2:0][2:0] window_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOAD,
        S_EMIT
    } state_t;

    // one mean request: first used column and first used row of the window
    typedef struct packed {
        logic       valid;
        logic [1:0] clo;
        logic [1:0] rlo;
        logic       last_of_run;
        logic       last_of_frame;
    } mean_req_t;

    typedef struct packed {
        sample_t blurred;
        logic    last_of_run;
        logic    last_of_frame;
    } result_t;

    // ceil(2^24 / count); exact floor for biased sums below 2^20
    function automatic logic [RECIP_W-1:0] div_recip(input logic [3:0] cnt);
        logic [RECIP_W-1:0] m;
        case (cnt)
            4'd1:    m = 25'd16777216;
            4'd2:    m = 25'd8388608;
            4'd3:    m = 25'd5592406;
            4'd4:    m = 25'd4194304;
            4'd6:    m = 25'd2796203;
            4'd9:    m = 25'd1864136;
            default: m = 25'd16777216;
        endcase
        return m;
    endfunction

    // bias divided by count, removed after the divide
    function automatic logic [OFFSET_W-1:0] div_offset(input logic [3:0] cnt);
        logic [OFFSET_W-1:0] o;
        case (cnt)
            4'd1:    o = 19'd294912;
            4'd2:    o = 19'd147456;
            4'd3:    o = 19'd98304;
            4'd4:    o = 19'd73728;
            4'd6:    o = 19'd49152;
            4'd9:    o = 19'd32768;
            default: o = 19'd294912;
        endcase
        return o;
    endfunction

endpackage

`default_nettype wire

@@ rtl/bbm_line_store.sv @@
// ----------------------------------------------------------------------------
// bbm_line_store
// Two row memories (row two above, row just above), one shared write address
// and one shared read address, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module bbm_line_store import bbm_pkg::*;
#(
    parameter int DEPTH = 32
)
(
    input  wire logic                                  clk,
    input  wire logic                                  we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire sample_t                               upper_wdata,
    input  wire sample_t                               middle_wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output sample_t                                    upper_rdata,
    output sample_t                                    middle_rdata
);

    sample_t upper_mem  [DEPTH];
    sample_t middle_mem [DEPTH];

    // write both rows at one column, read both rows at one column
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            upper_mem[waddr]  <= upper_wdata;
            middle_mem[waddr] <= middle_wdata;
        end
        upper_rdata  <= upper_mem[raddr];
        middle_rdata <= middle_mem[raddr];
    end

endmodule

`default_nettype wire

@@ rtl/bbm_mean.sv @@
// ----------------------------------------------------------------------------
// bbm_mean
// Four-stage mean of the selected part of the 3x3 window: column sums,
// biased total, reciprocal multiply, bias removal. Floors toward minus infinity.
// ----------------------------------------------------------------------------
`default_nettype none

module bbm_mean import bbm_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire mean_req_t req,
    input  wire window_t   win,
    output logic           res_valid,
    output result_t        res
);

    logic signed [COL_SUM_W-1:0] col_sum [3];
    logic [1:0]                  ncol;
    logic [1:0]                  nrow;
    logic [3:0]                  cnt;

    logic                        s1_valid_reg;
    logic signed [COL_SUM_W-1:0] s1_sum_reg [3];
    logic [3:0]                  s1_cnt_reg;
    logic                        s1_lr_reg;
    logic                        s1_lf_reg;

    logic signed [SUM_W-1:0]     total;
    logic [SUM_W-1:0]            biased;
    logic                        s2_valid_reg;
    logic [SUM_W-1:0]            s2_u_reg;
    logic [3:0]                  s2_cnt_reg;
    logic                        s2_lr_reg;
    logic                        s2_lf_reg;

    logic [PROD_W-1:0]           prod;
    logic                        s3_valid_reg;
    logic [SUM_W-1:0]            s3_q_reg;
    logic [3:0]                  s3_cnt_reg;
    logic                        s3_lr_reg;
    logic                        s3_lf_reg;

    logic [SUM_W-1:0]            diff;
    logic                        s4_valid_reg;
    result_t                     s4_res_reg;

    // column sums over the rows in use, unused columns forced to zero
    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            col_sum[c] = '0;
            for (int r = 0; r < 3; r++)
            begin
                if (2'(r) >= req.rlo && 2'(c) >= req.clo)
                begin
                    col_sum[c] = col_sum[c] + COL_SUM_W'(win[r][c]);
                end
            end
        end
    end

    // number of positions in the neighborhood
    assign ncol = 2'd3 - req.clo;
    assign nrow = 2'd3 - req.rlo;
    assign cnt  = {2'b00, ncol} * {2'b00, nrow};

    // total plus bias, never negative
    assign total  = SUM_W'(s1_sum_reg[0]) + SUM_W'(s1_sum_reg[1]) + SUM_W'(s1_sum_reg[2]);
    assign biased = $unsigned(total) + SUM_BIAS;

    // divide by reciprocal multiply
    assign prod = PROD_W'(s2_u_reg) * PROD_W'(div_recip(s2_cnt_reg));

    // remove the divided bias
    assign diff = s3_q_reg - SUM_W'(div_offset(s3_cnt_reg));

    // stage valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= req.valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
        end
    end

    // stage payloads
    always_ff @(posedge clk)
    begin
        s1_sum_reg[0] <= col_sum[0];
        s1_sum_reg[1] <= col_sum[1];
        s1_sum_reg[2] <= col_sum[2];
        s1_cnt_reg    <= cnt;
        s1_lr_reg     <= req.last_of_run;
        s1_lf_reg     <= req.last_of_frame;

        s2_u_reg      <= biased;
        s2_cnt_reg    <= s1_cnt_reg;
        s2_lr_reg     <= s1_lr_reg;
        s2_lf_reg     <= s1_lf_reg;

        s3_q_reg      <= prod[RECIP_SHIFT +: SUM_W];
        s3_cnt_reg    <= s2_cnt_reg;
        s3_lr_reg     <= s2_lr_reg;
        s3_lf_reg     <= s2_lf_reg;

        s4_res_reg.blurred       <= sample_t'(diff[SAMPLE_W-1:0]);
        s4_res_reg.last_of_run   <= s3_lr_reg;
        s4_res_reg.last_of_frame <= s3_lf_reg;
    end

    assign res_valid = s4_valid_reg;
    assign res       = s4_res_reg;

endmodule

`default_nettype wire

@@ rtl/bbm_out_fifo.sv @@
// ----------------------------------------------------------------------------
// bbm_out_fifo
// Small result buffer between the mean pipeline and the output channel;
// the issuer keeps it from overflowing by counting credits.
// ----------------------------------------------------------------------------
`default_nettype none

module bbm_out_fifo import bbm_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    push,
    input  wire result_t din,
    input  wire logic    pop,
    output logic         not_empty,
    output result_t      dout
);

    localparam int PTR_W = $clog2(FIFO_DEPTH);
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

    result_t          buf_mem [FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    // occupancy
    always_comb
    begin
        count_next = count_reg;
        case ({push, pop})
            2'b10:   count_next = count_reg + CNT_W'(1);
            2'b01:   count_next = count_reg - CNT_W'(1);
            default: count_next = count_reg;
        endcase
    end

    // pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            buf_mem[wr_ptr_reg] <= din;
        end
    end

    assign not_empty = (count_reg != '0);
    assign dout      = buf_mem[rd_ptr_reg];

endmodule

`default_nettype wire

@@ rtl/box_blur_3x3_edge_mean_core.sv @@
// ----------------------------------------------------------------------------
// box_blur_3x3_edge_mean_core
// Streaming 3x3 box blur with edge-aware divisor over a raster frame of
// signed Q4.11 samples; two row memories hold the previous rows.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one sample per item in raster order. m_axis carries the
//   floored mean of each position's in-bounds 3x3 neighborhood, in raster
//   order; tlast marks the last result an input item causes, tuser the
//   result for the final position of the frame.
//   An input at column x of row y (y >= 1) releases the result for column
//   x-1 of row y-1, and at the row's last column also column x of row y-1.
//   The final input of a frame then flushes the whole last row.
//   Each item passes through a row memory read-modify-write: read, load
//   the window and write back, then issue one result per cycle while
//   buffer credits last. The frame-end flush sweeps the row memories one
//   column at a time, loading the window and issuing as for an input item.
//   The first result of an item reaches m_axis after the load, the issue,
//   the 4-stage mean pipeline and the buffer write.
//   When m_axis stalls, results collect in an 8-entry buffer; issue waits
//   on buffer credits and s_axis holds off until the item's results issue.
//   Reset clears the position counters, sets height to 32 and width to 32 (at most MAX_WIDTH).
//   Row memories are not cleared; a configuration write restarts the frame.
// ----------------------------------------------------------------------------
`default_nettype none

module box_blur_3x3_edge_mean_core import bbm_pkg::*;
#(
    parameter int MAX_WIDTH = 32
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // input items
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic signed [15:0]    s_axis_tdata,   // [15:0] sample
    // result items
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    output logic signed [15:0]         m_axis_tdata,   // [15:0] blurred
    output logic                       m_axis_tlast,
    output logic                       m_axis_tuser,   // [0] last_of_frame
    // configuration writes
    input  wire logic                  cfg_wen,
    input  wire logic                  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int XW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);
    localparam logic [6:0] MAXW_V = 7'(MAX_WIDTH);
    localparam int RST_COLS = (FRAME_WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH : FRAME_WIDTH_RESET;
    localparam logic [XW-1:0]    RST_LAST_COL = XW'(RST_COLS - 1);
    localparam logic [ROW_W-1:0] RST_LAST_ROW = ROW_W'(FRAME_HEIGHT_RESET - 1);

    state_t            state_reg, state_next;
    logic [XW-1:0]     cur_col_reg, cur_col_next;
    logic [XW-1:0]     col_reg, col_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic              flushing_reg, flushing_next;
    logic [1:0]        pend_reg, pend_next;
    logic [1:0]        rlo_reg, rlo_next;
    sample_t           sample_reg;
    window_t           window_reg, window_next;
    logic [XW-1:0]     last_col_reg, last_col_next;
    logic [ROW_W-1:0]  last_row_reg, last_row_next;
    logic [CNT_W-1:0]  credit_reg, credit_next;

    logic              in_acc;
    logic              out_acc;
    logic              credit_ok;
    logic              at_last_col;
    logic              frame_end;
    logic [1:0]        remain;
    logic              issue;
    logic              step_done;
    logic              go_load;
    logic              row_active;
    logic              mem_we;
    sample_t           upper_rd;
    sample_t           middle_rd;
    mean_req_t         req;
    logic              res_valid;
    result_t           res;
    result_t           out_res;
    logic [5:0]        wreq;
    logic [12:0]       hreq;

    assign in_acc  = s_axis_tvalid && s_axis_tready;
    assign out_acc = m_axis_tvalid && m_axis_tready;

    // row memories
    bbm_line_store #(
        .DEPTH (MAX_WIDTH)
    ) u_lines (
        .clk          (clk),
        .we           (mem_we),
        .waddr        (cur_col_reg),
        .upper_wdata  (middle_rd),
        .middle_wdata (sample_reg),
        .raddr        (cur_col_next),
        .upper_rdata  (upper_rd),
        .middle_rdata (middle_rd)
    );

    // position decode
    assign at_last_col = (cur_col_reg == last_col_reg);
    assign frame_end   = at_last_col && (row_reg == last_row_reg);
    assign credit_ok   = (credit_reg < CNT_W'(FIFO_DEPTH));
    assign remain      = pend_reg & ~(pend_reg[0] ? 2'b01 : 2'b10);
    assign row_active  = flushing_reg || (row_reg != '0);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    state_next = S_LOAD;
                end
            end
            S_LOAD:
            begin
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (step_done)
                begin
                    state_next = go_load ? S_LOAD : S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb
    begin
        s_axis_tready     = 1'b0;
        mem_we            = 1'b0;
        issue             = 1'b0;
        step_done         = 1'b0;
        go_load           = 1'b0;
        req.valid         = 1'b0;
        req.clo           = 2'd0;
        req.rlo           = rlo_reg;
        req.last_of_run   = 1'b0;
        req.last_of_frame = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                s_axis_tready = 1'b1;
            end
            S_LOAD:
            begin
                // write back only for real input items, not during the flush sweep
                mem_we = !flushing_reg;
            end
            S_EMIT:
            begin
                issue     = (pend_reg != 2'b00) && credit_ok;
                step_done = (pend_reg == 2'b00) || (issue && remain == 2'b00);
                go_load   = step_done && (flushing_reg ? !at_last_col : frame_end);
                req.valid = issue;
                if (pend_reg[0])
                begin
                    req.clo = (cur_col_reg > XW'(1)) ? 2'd0 : 2'd1;
                end
                else
                begin
                    req.clo = (cur_col_reg != '0) ? 2'd1 : 2'd2;
                end
                req.last_of_run   = (remain == 2'b00) &&
                                    (flushing_reg ? at_last_col : !frame_end);
                req.last_of_frame = (remain == 2'b00) && flushing_reg && at_last_col;
            end
            default:
            begin
                s_axis_tready = 1'b0;
            end
        endcase
    end

    // column, row, window and pending results
    always_comb
    begin
        cur_col_next  = cur_col_reg;
        col_next      = col_reg;
        row_next      = row_reg;
        flushing_next = flushing_reg;
        pend_next     = pend_reg;
        rlo_next      = rlo_reg;
        window_next   = window_reg;

        if (in_acc)
        begin
            cur_col_next = col_reg;
        end

        if (state_reg == S_LOAD)
        begin
            // shift in the new column: flush uses the two stored rows only
            for (int r = 0; r < 3; r++)
            begin
                window_next[r][0] = window_reg[r][1];
                window_next[r][1] = window_reg[r][2];
            end
            window_next[0][2] = upper_rd;
            window_next[1][2] = flushing_reg ? upper_rd : middle_rd;
            window_next[2][2] = flushing_reg ? middle_rd : sample_reg;
            pend_next = {row_active && at_last_col, row_active && (cur_col_reg != '0)};
            if (flushing_reg)
            begin
                rlo_next = (row_reg != '0) ? 2'd1 : 2'd2;
            end
            else
            begin
                rlo_next = (row_reg > ROW_W'(1)) ? 2'd0 : 2'd1;
            end
        end

        if (issue)
        begin
            pend_next = remain;
        end

        if (step_done)
        begin
            if (go_load)
            begin
                // start or continue the flush sweep
                cur_col_next  = flushing_reg ? (cur_col_reg + XW'(1)) : '0;
                flushing_next = 1'b1;
            end
            else if (flushing_reg)
            begin
                // flush finished: next frame starts at the origin
                flushing_next = 1'b0;
                col_next      = '0;
                row_next      = '0;
            end
            else if (at_last_col)
            begin
                col_next = '0;
                row_next = row_reg + ROW_W'(1);
            end
            else
            begin
                col_next = col_reg + XW'(1);
            end
        end

        if (cfg_wen)
        begin
            col_next = '0;
            row_next = '0;
        end
    end

    // clamp register writes to the supported frame size (width from data bits [5:0] only)
    assign wreq = cfg_data[5:0];
    assign hreq = cfg_data[12:0];

    always_comb
    begin
        last_col_next = last_col_reg;
        last_row_next = last_row_reg;
        if (cfg_wen)
        begin
            case (cfg_index)
                REG_FRAME_WIDTH:
                begin
                    if (wreq == 6'd0)
                    begin
                        last_col_next = '0;
                    end
                    else if ({1'b0, wreq} > MAXW_V)
                    begin
                        last_col_next = XW'(MAX_WIDTH - 1);
                    end
                    else
                    begin
                        last_col_next = XW'(wreq - 6'd1);
                    end
                end
                REG_FRAME_HEIGHT:
                begin
                    if (hreq == 13'd0)
                    begin
                        last_row_next = '0;
                    end
                    else if (hreq > 13'(MAX_HEIGHT))
                    begin
                        last_row_next = ROW_W'(MAX_HEIGHT - 1);
                    end
                    else
                    begin
                        last_row_next = ROW_W'(hreq - 13'd1);
                    end
                end
                default:
                begin
                    last_col_next = last_col_reg;
                end
            endcase
        end
    end

    // result credits: issued and not yet taken at the output
    always_comb
    begin
        credit_next = credit_reg;
        case ({issue, out_acc})
            2'b10:   credit_next = credit_reg + CNT_W'(1);
            2'b01:   credit_next = credit_reg - CNT_W'(1);
            default: credit_next = credit_reg;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            cur_col_reg  <= '0;
            col_reg      <= '0;
            row_reg      <= '0;
            flushing_reg <= 1'b0;
            pend_reg     <= 2'b00;
            rlo_reg      <= 2'd0;
            last_col_reg <= RST_LAST_COL;
            last_row_reg <= RST_LAST_ROW;
            credit_reg   <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            cur_col_reg  <= cur_col_next;
            col_reg      <= col_next;
            row_reg      <= row_next;
            flushing_reg <= flushing_next;
            pend_reg     <= pend_next;
            rlo_reg      <= rlo_next;
            last_col_reg <= last_col_next;
            last_row_reg <= last_row_next;
            credit_reg   <= credit_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            sample_reg <= s_axis_tdata;
        end
        window_reg <= window_next;
    end

    // mean pipeline
    bbm_mean u_mean (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .win       (window_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    // result buffer
    bbm_out_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_valid),
        .din       (res),
        .pop       (out_acc),
        .not_empty (m_axis_tvalid),
        .dout      (out_res)
    );

    assign m_axis_tdata = out_res.blurred;
    assign m_axis_tlast = out_res.last_of_run;
    assign m_axis_tuser = out_res.last_of_frame;

endmodule

`default_nettype wire

@@ rtl/bbm_checker.sv @@
// ----------------------------------------------------------------------------
// bbm_checker
// Port-level checks for the box blur core, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module bbm_checker
(
    input wire logic                  clk,
    input wire logic                  rst_n,
    input wire logic                  s_axis_tvalid,
    input wire logic                  s_axis_tready,
    input wire logic                  m_axis_tvalid,
    input wire logic                  m_axis_tready,
    input wire logic signed [15:0]    m_axis_tdata,
    input wire logic                  m_axis_tlast,
    input wire logic                  m_axis_tuser,
    input wire logic                  cfg_wen
);

    // frame end always closes the run of its item
    a_frame_closes_run: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
        else $error("last_of_frame without last_of_run");

    // one item in work at a time: input closes right after an accept
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input accepted while previous item still in work");

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast) &&
            $stable(m_axis_tuser))
        else $error("stalled result changed");

    // nothing offered once reset has been applied
    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |=> !m_axis_tvalid)
        else $error("result offered during reset");

    // register writes must land only while the block is idle and drained; the core does not enforce it
    a_cfg_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_wen |-> s_axis_tready && !m_axis_tvalid)
        else $error("register written while an item is in work");

endmodule

bind box_blur_3x3_edge_mean_core bbm_checker u_bbm_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_wen       (cfg_wen)
);

`default_nettype wire
